[rtl/cia_pkg.sv]
// Package for the checked integer ALU: operation codes, widths and controller commands.
// Used by cia_ctrl, cia_datapath and checked_int64_alu; depends on nothing.
`timescale 1ns / 1ps
package cia_pkg;
  localparam int unsigned OpWidth = 3;
  localparam int unsigned IoWidth = 64;
  localparam int unsigned DefaultDataWidth = 64;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_POW = 3'd4,
    OP_NEG = 3'd5,
    OP_MAX = 3'd6,
    OP_MIN = 3'd7
  } op_t;

  typedef struct packed {
    logic load;
    logic simple;
    logic mul_start;
    logic mul_sel_square;
    logic div_start;
    logic div_step;
    logic pow_shift;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic exp_zero;
    logic exp_low;
    logic exp_one;
    logic failed;
    logic is_pow;
    logic is_mul;
    logic is_div;
  } status_t;
endpackage

[rtl/cia_ctrl.sv]
// Controller state machine for the checked integer ALU.
// Depends on cia_pkg for the command and status structures.
`timescale 1ns / 1ps
module cia_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_fire,
  input  logic             out_free,
  input  cia_pkg::status_t sts,
  output cia_pkg::cmd_t    cmd,
  output logic             busy
);
  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_MUL, S_DIV, S_POW_TEST, S_POW_MUL, S_POW_SQ_GO, S_POW_SQ, S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.is_mul) begin
          cmd.mul_start = 1'b1;
          state_next = S_MUL;
        end else if (sts.is_div) begin
          cmd.div_start = 1'b1;
          state_next = S_DIV;
        end else if (sts.is_pow) begin
          state_next = S_POW_TEST;
        end else begin
          cmd.simple = 1'b1;
          state_next = S_DONE;
        end
      end
      S_MUL: begin
        if (sts.mul_done) begin
          state_next = S_DONE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_next = S_DONE;
        end
      end
      S_POW_TEST: begin
        if (sts.failed || sts.exp_zero) begin
          state_next = S_DONE;
        end else if (sts.exp_low) begin
          cmd.mul_start = 1'b1;
          state_next = S_POW_MUL;
        end else if (!sts.exp_one) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel_square = 1'b1;
          state_next = S_POW_SQ;
        end else begin
          cmd.pow_shift = 1'b1;
        end
      end
      S_POW_MUL: begin
        if (sts.mul_done) begin
          if (sts.exp_one) begin
            cmd.pow_shift = 1'b1;
            state_next = S_POW_TEST;
          end else begin
            state_next = S_POW_SQ_GO;
          end
        end
      end
      S_POW_SQ_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel_square = 1'b1;
        state_next = S_POW_SQ;
      end
      S_POW_SQ: begin
        if (sts.mul_done) begin
          cmd.pow_shift = 1'b1;
          state_next = S_POW_TEST;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

[rtl/cia_datapath.sv]
// Datapath of the checked integer ALU: operand registers, a 64x64 multi-cycle
// multiplier with range check, a restoring divider and the power registers. Uses cia_pkg.
`timescale 1ns / 1ps
module cia_datapath #(
  parameter int unsigned DATA_WIDTH = cia_pkg::DefaultDataWidth
) (
  input  logic                               clk,
  input  cia_pkg::cmd_t                      cmd,
  input  logic [cia_pkg::OpWidth-1:0]        op_in,
  input  logic [cia_pkg::IoWidth-1:0]        left_in,
  input  logic [cia_pkg::IoWidth-1:0]        right_in,
  output cia_pkg::status_t                   sts,
  output logic [cia_pkg::IoWidth-1:0]        res_value,
  output logic                               res_ok
);
  localparam int unsigned W = DATA_WIDTH;
  localparam int unsigned HW = (W + 1) / 2;
  localparam int unsigned CW = $clog2(W + 1);

  logic [2:0]   op;
  logic [W-1:0] a;
  logic [W-1:0] b;
  logic [W-1:0] acc;
  logic         fail;

  // Multiplier: magnitudes split into halves, four partial products accumulated in turn.
  logic [W-1:0]   ma;
  logic [W-1:0]   mb;
  logic           mneg;
  logic           mzero;
  logic [2:0]     mcnt;
  logic           mbusy;
  logic [2*W-1:0] mprod;
  logic           msq;

  logic [W-1:0] ux;
  logic [W-1:0] uy;
  logic [W-1:0] mx_src;
  logic [W-1:0] my_src;
  logic [HW-1:0] pa;
  logic [HW-1:0] pb;
  logic [2*HW-1:0] pp;
  logic [2*W-1:0] pp_sh;
  logic [W-1:0] mres;
  logic         mok;

  function automatic logic [W-1:0] mag(input logic [W-1:0] x);
    mag = x[W-1] ? (~x + 1'b1) : x;
  endfunction

  assign mx_src = cmd.mul_sel_square ? b : acc;
  assign my_src = b;
  assign ux = (op == cia_pkg::OP_MUL) ? a : mx_src;
  assign uy = (op == cia_pkg::OP_MUL) ? b : my_src;

  always_comb begin
    pa = mcnt[0] ? HW'(ma >> HW) : ma[HW-1:0];
    pb = mcnt[1] ? HW'(mb >> HW) : mb[HW-1:0];
  end
  assign pp = pa * pb;
  always_comb begin
    pp_sh = (2*W)'(pp) << ((mcnt[0] ? HW : 0) + (mcnt[1] ? HW : 0));
  end

  always_comb begin
    logic [2*W-1:0] lim;
    lim = {{W{1'b0}}, 1'b0, {(W-1){1'b1}}} + (2*W)'(mneg);
    mok = mzero || (mprod <= lim);
    mres = mneg ? (~mprod[W-1:0] + 1'b1) : mprod[W-1:0];
    if (mzero) mres = '0;
  end

  // Divider: restoring, one quotient bit a cycle.
  logic [W-1:0] dq;
  logic [W:0]   drem;
  logic [W-1:0] dd;
  logic [CW-1:0] dcnt;
  logic         dqneg;
  logic [W:0]   dtrial;

  assign dtrial = {drem[W-1:0], dq[W-1]} - {1'b0, dd};

  logic [W-1:0] addr;
  logic [W-1:0] subr;
  logic         add_ovf;
  logic         sub_ovf;
  logic         a_min;
  logic         a_lt_b;

  assign addr = a + b;
  assign subr = a - b;
  assign add_ovf = (a[W-1] == b[W-1]) && (addr[W-1] != a[W-1]);
  assign sub_ovf = (a[W-1] != b[W-1]) && (subr[W-1] != a[W-1]);
  assign a_min = a[W-1] && (a[W-2:0] == '0);
  assign a_lt_b = $signed(a) < $signed(b);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= op_in;
      a <= (op_in == cia_pkg::OP_POW) ? right_in[W-1:0] : left_in[W-1:0];
      b <= (op_in == cia_pkg::OP_POW) ? left_in[W-1:0] : right_in[W-1:0];
      acc <= W'(1);
      fail <= (op_in == cia_pkg::OP_POW) && right_in[W-1];
      mbusy <= 1'b0;
    end
    if (cmd.simple) begin
      unique case (cia_pkg::op_t'(op))
        cia_pkg::OP_ADD: begin acc <= addr; fail <= add_ovf; end
        cia_pkg::OP_SUB: begin acc <= subr; fail <= sub_ovf; end
        cia_pkg::OP_NEG: begin acc <= -a; fail <= a_min; end
        cia_pkg::OP_MAX: begin acc <= a_lt_b ? b : a; fail <= 1'b0; end
        cia_pkg::OP_MIN: begin acc <= a_lt_b ? a : b; fail <= 1'b0; end
        default: fail <= 1'b1;
      endcase
    end
    if (cmd.mul_start) begin
      msq <= cmd.mul_sel_square;
      ma <= mag(ux);
      mb <= mag(uy);
      mneg <= ux[W-1] ^ uy[W-1];
      mzero <= (ux == '0) || (uy == '0);
      mprod <= '0;
      mcnt <= '0;
      mbusy <= 1'b1;
    end else if (mbusy) begin
      if (mcnt[2]) begin
        mbusy <= 1'b0;
        if (!mok) begin
          fail <= 1'b1;
        end else if (op == cia_pkg::OP_MUL || !msq) begin
          acc <= mres;
        end else begin
          b <= mres;
        end
      end else begin
        mprod <= mprod + pp_sh;
        mcnt <= mcnt + 3'd1;
      end
    end
    if (cmd.div_start) begin
      dq <= mag(a);
      dd <= mag(b);
      drem <= '0;
      dcnt <= '0;
      dqneg <= a[W-1] ^ b[W-1];
      fail <= (b == '0) || (a_min && (b == '1));
    end else if (cmd.div_step && dcnt != CW'(W)) begin
      if (!dtrial[W]) begin
        drem <= dtrial;
        dq <= {dq[W-2:0], 1'b1};
      end else begin
        drem <= {drem[W-1:0], dq[W-1]};
        dq <= {dq[W-2:0], 1'b0};
      end
      dcnt <= dcnt + 1'b1;
    end else if (cmd.div_step) begin
      acc <= dqneg ? -dq : dq;
    end
    if (cmd.pow_shift) begin
      a <= a >> 1;
    end
  end

  always_comb begin
    sts = '0;
    sts.mul_done = mbusy && mcnt[2];
    sts.div_done = cmd.div_step && dcnt == CW'(W);
    sts.exp_zero = (a == '0);
    sts.exp_low = a[0];
    sts.exp_one = (a[W-1:1] == '0);
    sts.failed = fail;
    sts.is_pow = (op == cia_pkg::OP_POW);
    sts.is_mul = (op == cia_pkg::OP_MUL);
    sts.is_div = (op == cia_pkg::OP_DIV);
  end

  assign res_ok = !fail;
  assign res_value = fail ? '0 : cia_pkg::IoWidth'($signed(acc));
endmodule

[rtl/checked_int64_alu.sv]
// Top level of the overflow-checked signed ALU with stream ports.
// Instantiates cia_ctrl and cia_datapath; depends on cia_pkg.
//
// Channel  Direction  tdata (low bit up)                              tuser
// s_axis   in         operation[2:0], left[66:3], right[130:67], pad  -
// m_axis   out        result_value[63:0], result_valid[64], pad       -
//
// Add, subtract, negate, max and min are computed in the dispatch state.
// Multiply runs the multiplier; divide forms all DATA_WIDTH quotient bits in turn.
// Power walks the exponent bits, multiplying and squaring on the shared multiplier.
// One item is in work at a time; the result register holds while m_axis_tready is low.
// Reset is synchronous and clears the controller and the output valid.
`timescale 1ns / 1ps
module checked_int64_alu #(
  parameter int unsigned DATA_WIDTH = cia_pkg::DefaultDataWidth
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,  // operation, left_operand, right_operand
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [71:0]  m_axis_tdata   // result_value, result_valid
);
  cia_pkg::cmd_t    cmd;
  cia_pkg::status_t sts;
  logic             busy;
  logic             in_fire;
  logic             out_free;
  logic [63:0]      res_value;
  logic             res_ok;
  logic [63:0]      out_value;
  logic             out_ok;

  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  cia_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_free(out_free),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  cia_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk(clk), .cmd(cmd), .op_in(s_axis_tdata[2:0]),
    .left_in(s_axis_tdata[66:3]), .right_in(s_axis_tdata[130:67]),
    .sts(sts), .res_value(res_value), .res_ok(res_ok)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (cmd.finish) begin
      out_value <= res_value;
      out_ok <= res_ok;
    end
  end

  assign m_axis_tdata = {7'd0, out_ok, out_value};
endmodule

[sim/checked_int64_alu_checker.sv]
// Checker for the checked integer ALU: watches both stream channels, predicts each result
// and compares it field by field. Depends on cia_pkg for the operation codes.
`timescale 1ns / 1ps
module checked_int64_alu_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [71:0]  m_axis_tdata,
  output int           fail_count,
  output int           pending_count,
  output int           result_count
);
  typedef struct packed {
    logic [63:0] value;
    logic        ok;
  } alu_result_t;

  localparam longint SMAX = 64'sh7fff_ffff_ffff_ffff;
  localparam longint SMIN = 64'sh8000_0000_0000_0000;

  alu_result_t expected_results[$];

  function automatic bit checked_mul(input longint a, input longint b, output longint p);
    logic signed [127:0] wide;
    wide = 128'(signed'(a)) * 128'(signed'(b));
    p = wide[63:0];
    return (wide <= 128'(signed'(SMAX))) && (wide >= 128'(signed'(SMIN)));
  endfunction

  function automatic alu_result_t compute_alu(input cia_pkg::op_t op, input longint a,
                                              input longint b);
    alu_result_t res;
    longint r, acc, base, ex;
    logic signed [64:0] wide;
    bit ok;
    r = 0;
    ok = 1'b0;
    case (op)
      cia_pkg::OP_ADD: begin
        wide = 65'(a) + 65'(b);
        ok = (wide[64] == wide[63]);
        r = wide[63:0];
      end
      cia_pkg::OP_SUB: begin
        wide = 65'(a) - 65'(b);
        ok = (wide[64] == wide[63]);
        r = wide[63:0];
      end
      cia_pkg::OP_MUL: ok = checked_mul(a, b, r);
      cia_pkg::OP_DIV: begin
        if (b != 0 && !(a == SMIN && b == -1)) begin
          r = a / b;
          ok = 1'b1;
        end
      end
      cia_pkg::OP_POW: begin
        if (b >= 0) begin
          acc = 1;
          base = a;
          ex = b;
          ok = 1'b1;
          while (ex != 0 && ok) begin
            if (ex[0]) ok = checked_mul(acc, base, acc);
            ex = ex >>> 1;
            if (ok && ex != 0) ok = checked_mul(base, base, base);
          end
          r = acc;
        end
      end
      cia_pkg::OP_NEG: begin
        if (a != SMIN) begin
          r = -a;
          ok = 1'b1;
        end
      end
      cia_pkg::OP_MAX: begin
        r = (b > a) ? b : a;
        ok = 1'b1;
      end
      default: begin
        r = (b < a) ? b : a;
        ok = 1'b1;
      end
    endcase
    res.value = ok ? r : 64'd0;
    res.ok = ok;
    return res;
  endfunction

  always @(posedge clk) begin
    alu_result_t want, got;
    if (rst) begin
      fail_count <= 0;
      result_count <= 0;
      expected_results.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(compute_alu(cia_pkg::op_t'(s_axis_tdata[2:0]),
                                               s_axis_tdata[66:3], s_axis_tdata[130:67]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.value = m_axis_tdata[63:0];
        got.ok = m_axis_tdata[64];
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("ERROR: result with no pending item: %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (want.value !== got.value || want.ok !== got.ok) begin
            if (fail_count < 10) begin
              $display("ERROR: value exp %h got %h, valid exp %b got %b",
                       want.value, got.value, want.ok, got.ok);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending_count = expected_results.size();
  end
endmodule

[sim/checked_int64_alu_tb.sv]
// Testbench top for the checked integer ALU: drives directed and random operations with
// random idling on both channels and gives the verdict. Depends on cia_pkg and the checker.
`timescale 1ns / 1ps
module checked_int64_alu_tb;
  localparam longint SMAX = 64'sh7fff_ffff_ffff_ffff;
  localparam longint SMIN = 64'sh8000_0000_0000_0000;
  localparam int CYCLE_LIMIT = 1_500_000;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [71:0]  m_axis_tdata;
  int           fail_count, pending_count, result_count;
  int           send_idle_pct, recv_idle_pct;
  int           hold_cycles;
  int           cycle_count;
  int           op_seen[8];

  checked_int64_alu uut (.*);

  checked_int64_alu_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic longint pick_operand();
    case ($urandom_range(9))
      0: return SMAX;
      1: return SMIN;
      2: return longint'($urandom_range(4)) - 2;
      3: return longint'($urandom_range(40)) - 20;
      4: return longint'(signed'($urandom)) >>> $urandom_range(31);
      5: return {$urandom, $urandom} >> $urandom_range(63);
      6: return -longint'({$urandom, $urandom} >> $urandom_range(63));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_item(input cia_pkg::op_t op, input longint a, input longint b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tdata <= {5'd0, b, a, op};
    s_axis_tvalid <= 1'b1;
    op_seen[op]++;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random_item();
    cia_pkg::op_t op;
    longint a, b;
    op = cia_pkg::op_t'($urandom_range(7));
    a = pick_operand();
    b = pick_operand();
    if (op == cia_pkg::OP_POW && $urandom_range(3) != 0) begin
      a = longint'($urandom_range(20)) - 10;
      b = $urandom_range(70);
      if ($urandom_range(9) == 0) b = {$urandom, $urandom};
    end
    send_item(op, a, b);
  endtask

  initial begin
    cycle_count = 0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_item(cia_pkg::OP_ADD, SMAX, 1);
    send_item(cia_pkg::OP_ADD, SMIN, -1);
    send_item(cia_pkg::OP_ADD, SMAX, SMIN);
    send_item(cia_pkg::OP_SUB, SMIN, 1);
    send_item(cia_pkg::OP_SUB, 0, SMIN);
    send_item(cia_pkg::OP_SUB, -1, SMIN);
    send_item(cia_pkg::OP_MUL, SMIN, -1);
    send_item(cia_pkg::OP_MUL, SMIN, 1);
    send_item(cia_pkg::OP_MUL, 64'sh1_0000_0000, 64'sh8000_0000);
    send_item(cia_pkg::OP_MUL, -64'sh1_0000_0000, 64'sh8000_0000);
    send_item(cia_pkg::OP_DIV, 5, 0);
    send_item(cia_pkg::OP_DIV, SMIN, -1);
    send_item(cia_pkg::OP_DIV, -7, 2);
    send_item(cia_pkg::OP_DIV, 7, -2);
    send_item(cia_pkg::OP_DIV, SMIN, SMAX);
    send_item(cia_pkg::OP_POW, 0, 0);
    send_item(cia_pkg::OP_POW, SMIN, 0);
    send_item(cia_pkg::OP_POW, 2, -1);
    send_item(cia_pkg::OP_POW, 2, 63);
    send_item(cia_pkg::OP_POW, -2, 63);
    send_item(cia_pkg::OP_POW, 3, 40);
    send_item(cia_pkg::OP_NEG, SMIN, 5);
    send_item(cia_pkg::OP_NEG, SMAX, 0);
    send_item(cia_pkg::OP_MAX, SMIN, SMAX);
    send_item(cia_pkg::OP_MIN, SMIN, SMAX);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 46 : 0;
      recv_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 36 : 0;
      if (phase == 2) hold_cycles = 400;
      for (int i = 0; i < 660; i++) send_random_item();
    end
    s_axis_tvalid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    $display("Sent %0d operations (add %0d sub %0d mul %0d div %0d pow %0d neg %0d",
             op_seen.sum(), op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4],
             op_seen[5]);
    $display("max %0d min %0d), checked %0d results under random idling and a long stall.",
             op_seen[6], op_seen[7], result_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
